### rtl/rts_pkg.sv
// ----------------------------------------------------------------------------
// rts_pkg
// Shared types, character codes and token helpers for the RPN token scanner.
// ----------------------------------------------------------------------------
`default_nettype none

package rts_pkg;

    // Error text store size, in characters
    localparam int MAX_TEXT   = 8;
    localparam int TEXT_IDX_W = (MAX_TEXT > 1) ? $clog2(MAX_TEXT) : 1;

    // Field widths
    localparam int COUNT_W = 4;
    localparam int MAG_W   = 27;
    localparam int MANT_W  = 28;
    localparam int FRAC_W  = 3;
    localparam int TEXT_W  = 64;

    // Result queue
    localparam int FIFO_DEPTH = 4;
    localparam int FIFO_PTR_W = $clog2(FIFO_DEPTH);
    localparam int FIFO_CNT_W = FIFO_PTR_W + 1;

    // Character codes
    localparam logic [7:0] CH_PLUS  = 8'h2B;
    localparam logic [7:0] CH_MINUS = 8'h2D;
    localparam logic [7:0] CH_SLASH = 8'h2F;
    localparam logic [7:0] CH_STAR  = 8'h2A;
    localparam logic [7:0] CH_DOT   = 8'h2E;
    localparam logic [7:0] CH_SPACE = 8'h20;
    localparam logic [7:0] CH_NL    = 8'h0A;
    localparam logic [7:0] CH_ZERO  = 8'h30;
    localparam logic [7:0] CH_NINE  = 8'h39;

    typedef enum logic [2:0] {
        KIND_NUMBER = 3'd0,
        KIND_ADD    = 3'd1,
        KIND_SUB    = 3'd2,
        KIND_MUL    = 3'd3,
        KIND_DIV    = 3'd4,
        KIND_ERR    = 3'd5,
        KIND_END    = 3'd6
    } t_tok_kind;

    typedef enum logic [2:0] {
        MODE_START = 3'd0,
        MODE_MINUS = 3'd1,
        MODE_INT   = 3'd2,
        MODE_FRAC  = 3'd3,
        MODE_ERROR = 3'd4
    } t_scan_mode;

    typedef struct packed {
        logic [7:0] char_code;
        logic       end_marker;
    } t_in_item;

    typedef struct packed {
        t_tok_kind                 token_kind;
        logic signed [MANT_W-1:0]  mantissa;
        logic [FRAC_W-1:0]         fraction_digits;
        logic [TEXT_W-1:0]         error_text;
        logic [COUNT_W-1:0]        error_length;
        logic                      text_overflow;
        logic                      last_of_run;
    } t_out_item;

    // Tokens produced by one scan step, first in tok0
    typedef struct packed {
        logic [1:0] n_tok;
        t_out_item  tok0;
        t_out_item  tok1;
    } t_push;

    // Token with no payload (operators, end)
    function automatic t_out_item tok_plain(input t_tok_kind kind);
        t_out_item t;
        t            = '0;
        t.token_kind = kind;
        return t;
    endfunction

endpackage

`default_nettype wire

### rtl/rpn_token_scanner.sv
// ----------------------------------------------------------------------------
// rpn_token_scanner
// Character-stream lexer for RPN arithmetic text: numbers, operators,
// lexical errors and an end token.
// ----------------------------------------------------------------------------
//
//  channel  direction  handshake                 payload
//  -------  ---------  ------------------------  ----------------------------
//  in       sink       i_in_valid / o_in_ready   i_in_item  (char, end mark)
//  out      source     o_out_valid / i_out_ready o_out_item (one token)
//
//  - One character per cycle while the queue has room: an accepted item
//    sits in the input register, is scanned in one pass and lands in the
//    4-entry token queue.
//  - The first token goes through the input register and the token queue.
//  - An item that ends a pending token may give two tokens; the queue drains
//    one per cycle while the out port is ready.
//  - The input register waits until the queue has room for two tokens.
//  - Synchronous active-low reset empties the queue and returns to start mode;
//    the error text store is not cleared (entries past the length are masked).
//
`default_nettype none

module rpn_token_scanner (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               i_in_valid,
    output logic                    o_in_ready,
    input  wire rts_pkg::t_in_item  i_in_item,
    output logic                    o_out_valid,
    input  wire logic               i_out_ready,
    output rts_pkg::t_out_item      o_out_item
);

    // Input register
    logic                   r_in_valid;
    rts_pkg::t_in_item      r_in_item;

    logic                   fifo_room;
    logic                   fire;
    rts_pkg::t_push         push;

    // Scan fires when the queue can take the worst case of two tokens
    assign fire       = r_in_valid && fifo_room;
    assign o_in_ready = !r_in_valid || fire;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (o_in_ready) begin
            r_in_valid <= i_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_in_ready && i_in_valid) begin
            r_in_item <= i_in_item;
        end
    end

    rts_scan u_scan (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_fire  (fire),
        .i_item  (r_in_item),
        .o_push  (push)
    );

    rts_tok_fifo u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .o_room  (fifo_room),
        .o_valid (o_out_valid),
        .i_ready (i_out_ready),
        .o_item  (o_out_item)
    );

endmodule

`default_nettype wire

### rtl/rts_scan.sv
// ----------------------------------------------------------------------------
// rts_scan
// Scanner state and single-step token logic: one character per fire.
// ----------------------------------------------------------------------------
`default_nettype none

module rts_scan (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             i_fire,
    input  wire rts_pkg::t_in_item i_item,
    output rts_pkg::t_push        o_push
);

    // State
    rts_pkg::t_scan_mode                 r_mode, n_mode;
    logic [rts_pkg::MAX_TEXT-1:0][7:0]   r_text;
    logic [rts_pkg::COUNT_W-1:0]         r_count, n_count;
    logic [rts_pkg::MAG_W-1:0]           r_mag, n_mag;
    logic [rts_pkg::FRAC_W-1:0]          r_pdc, n_pdc;
    logic                                r_neg, n_neg;
    logic                                r_ovf, n_ovf;

    logic [7:0]                      c;
    logic                            is_dig, is_val;
    logic [3:0]                      dval;
    logic                            room;
    logic [rts_pkg::MAG_W-1:0]       mag_x10;

    // Start-mode decode (state is always clean there)
    logic                            st_emit, st_store;
    rts_pkg::t_tok_kind              st_kind;
    rts_pkg::t_scan_mode             st_mode;

    logic                            wr_en;
    logic [rts_pkg::TEXT_IDX_W-1:0]  wr_idx;
    logic                            pre_emit, do_start, end_tok, sec_emit;
    rts_pkg::t_out_item              pre_tok, sec_tok, num_tok, err_tok;
    logic [rts_pkg::MANT_W-1:0]      mag_ext;

    assign c       = i_item.char_code;
    assign is_dig  = (c >= rts_pkg::CH_ZERO) && (c <= rts_pkg::CH_NINE);
    assign is_val  = is_dig || (c == rts_pkg::CH_PLUS) || (c == rts_pkg::CH_MINUS) ||
                     (c == rts_pkg::CH_SLASH) || (c == rts_pkg::CH_STAR) ||
                     (c == rts_pkg::CH_DOT) || (c == rts_pkg::CH_SPACE) ||
                     (c == rts_pkg::CH_NL);
    assign dval    = c[3:0];
    assign room    = r_count < rts_pkg::COUNT_W'(rts_pkg::MAX_TEXT);
    assign mag_x10 = rts_pkg::MAG_W'({r_mag, 3'b000} + {r_mag, 1'b0});
    assign mag_ext = {1'b0, r_mag};

    // Pending number / error tokens from current state
    always_comb begin
        num_tok                 = rts_pkg::tok_plain(rts_pkg::KIND_NUMBER);
        num_tok.mantissa        = r_neg ? -mag_ext : mag_ext;
        num_tok.fraction_digits = r_pdc;
        num_tok.text_overflow   = r_ovf;

        err_tok                 = rts_pkg::tok_plain(rts_pkg::KIND_ERR);
        err_tok.error_length    = r_count;
        err_tok.text_overflow   = r_ovf;
        for (int i = 0; i < rts_pkg::MAX_TEXT; i++) begin
            if (rts_pkg::COUNT_W'(i) < r_count) begin
                err_tok.error_text[8*i +: 8] = r_text[i];
            end
        end
    end

    always_comb begin
        st_emit  = 1'b0;
        st_store = 1'b0;
        st_kind  = rts_pkg::KIND_ADD;
        st_mode  = rts_pkg::MODE_START;
        if (c == rts_pkg::CH_PLUS) begin
            st_emit = 1'b1;
        end else if (c == rts_pkg::CH_STAR) begin
            st_emit = 1'b1;
            st_kind = rts_pkg::KIND_MUL;
        end else if (c == rts_pkg::CH_SLASH) begin
            st_emit = 1'b1;
            st_kind = rts_pkg::KIND_DIV;
        end else if (c == rts_pkg::CH_MINUS) begin
            st_mode  = rts_pkg::MODE_MINUS;
            st_store = 1'b1;
        end else if (is_dig) begin
            st_mode  = rts_pkg::MODE_INT;
            st_store = 1'b1;
        end else if (c == rts_pkg::CH_DOT) begin
            st_mode = rts_pkg::MODE_ERROR;
        end
    end

    // Next state
    always_comb begin
        n_mode   = r_mode;
        n_count  = r_count;
        n_mag    = r_mag;
        n_pdc    = r_pdc;
        n_neg    = r_neg;
        n_ovf    = r_ovf;
        wr_en    = 1'b0;
        wr_idx   = r_count[rts_pkg::TEXT_IDX_W-1:0];
        pre_emit = 1'b0;
        pre_tok  = rts_pkg::tok_plain(rts_pkg::KIND_SUB);
        do_start = 1'b0;
        end_tok  = 1'b0;

        if (i_item.end_marker) begin
            if (r_mode == rts_pkg::MODE_MINUS) begin
                pre_emit = 1'b1;
            end else if (r_mode == rts_pkg::MODE_ERROR) begin
                pre_emit = 1'b1;
                pre_tok  = err_tok;
            end
            end_tok = 1'b1;
            n_mode  = rts_pkg::MODE_START;
            n_count = '0;
            n_mag   = '0;
            n_pdc   = '0;
            n_neg   = 1'b0;
            n_ovf   = 1'b0;
        end else if (!is_val) begin
            n_mode = rts_pkg::MODE_ERROR;
            if (room) begin
                wr_en   = 1'b1;
                n_count = r_count + 1'b1;
            end else begin
                n_ovf = 1'b1;
            end
        end else begin
            case (r_mode)
                rts_pkg::MODE_MINUS, rts_pkg::MODE_INT, rts_pkg::MODE_FRAC: begin
                    if (is_dig) begin
                        if (r_mode == rts_pkg::MODE_MINUS) begin
                            n_mode = rts_pkg::MODE_INT;
                            n_neg  = 1'b1;
                        end
                        if (room) begin
                            wr_en   = 1'b1;
                            n_count = r_count + 1'b1;
                            n_mag   = mag_x10 + {{(rts_pkg::MAG_W-4){1'b0}}, dval};
                            if (r_mode == rts_pkg::MODE_FRAC) begin
                                n_pdc = r_pdc + 1'b1;
                            end
                        end else begin
                            n_ovf = 1'b1;
                        end
                    end else if (c == rts_pkg::CH_DOT) begin
                        if (r_mode == rts_pkg::MODE_INT) begin
                            n_mode = rts_pkg::MODE_FRAC;
                            if (room) begin
                                wr_en   = 1'b1;
                                n_count = r_count + 1'b1;
                            end else begin
                                n_ovf = 1'b1;
                            end
                        end else begin
                            n_mode = rts_pkg::MODE_ERROR;
                        end
                    end else begin
                        pre_emit = 1'b1;
                        if (r_mode != rts_pkg::MODE_MINUS) begin
                            pre_tok = num_tok;
                        end
                        do_start = 1'b1;
                    end
                end
                rts_pkg::MODE_ERROR: begin
                    pre_emit = 1'b1;
                    pre_tok  = err_tok;
                    do_start = 1'b1;
                end
                default: begin
                    do_start = 1'b1;
                end
            endcase

            // Terminating character is rescanned from a clean start
            if (do_start) begin
                n_mode  = st_mode;
                n_count = st_store ? rts_pkg::COUNT_W'(1) : '0;
                n_mag   = (st_mode == rts_pkg::MODE_INT) ?
                          {{(rts_pkg::MAG_W-4){1'b0}}, dval} : '0;
                n_pdc   = '0;
                n_neg   = 1'b0;
                n_ovf   = 1'b0;
                wr_en   = st_store;
                wr_idx  = '0;
            end
        end
    end

    // Token assembly
    always_comb begin
        sec_emit = end_tok || (do_start && st_emit);
        sec_tok  = end_tok ? rts_pkg::tok_plain(rts_pkg::KIND_END) :
                             rts_pkg::tok_plain(st_kind);
        sec_tok.last_of_run = 1'b1;

        o_push.n_tok = i_fire ? ({1'b0, pre_emit} + {1'b0, sec_emit}) : 2'd0;
        o_push.tok0  = pre_emit ? pre_tok : sec_tok;
        o_push.tok0.last_of_run = !(pre_emit && sec_emit);
        o_push.tok1  = sec_tok;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode  <= rts_pkg::MODE_START;
            r_count <= '0;
            r_mag   <= '0;
            r_pdc   <= '0;
            r_neg   <= 1'b0;
            r_ovf   <= 1'b0;
        end else if (i_fire) begin
            r_mode  <= n_mode;
            r_count <= n_count;
            r_mag   <= n_mag;
            r_pdc   <= n_pdc;
            r_neg   <= n_neg;
            r_ovf   <= n_ovf;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_fire && wr_en) begin
            r_text[wr_idx] <= c;
        end
    end

endmodule

`default_nettype wire

### rtl/rts_tok_fifo.sv
// ----------------------------------------------------------------------------
// rts_tok_fifo
// Small result queue: takes up to two tokens per cycle, gives one when ready.
// ----------------------------------------------------------------------------
`default_nettype none

module rts_tok_fifo (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire rts_pkg::t_push     i_push,
    output logic                    o_room,
    output logic                    o_valid,
    input  wire logic               i_ready,
    output rts_pkg::t_out_item      o_item
);

    rts_pkg::t_out_item                  r_mem [rts_pkg::FIFO_DEPTH];
    logic [rts_pkg::FIFO_PTR_W-1:0]      r_wr, n_wr, r_rd, n_rd, wr_next;
    logic [rts_pkg::FIFO_CNT_W-1:0]      r_cnt, n_cnt;
    logic                                pop;

    assign o_valid = (r_cnt != '0);
    assign o_item  = r_mem[r_rd];
    assign o_room  = r_cnt <= rts_pkg::FIFO_CNT_W'(rts_pkg::FIFO_DEPTH - 2);
    assign pop     = o_valid && i_ready;
    assign wr_next = r_wr + 1'b1;

    always_comb begin
        n_wr  = r_wr + rts_pkg::FIFO_PTR_W'(i_push.n_tok);
        n_rd  = pop ? r_rd + 1'b1 : r_rd;
        n_cnt = r_cnt + rts_pkg::FIFO_CNT_W'(i_push.n_tok)
                      - rts_pkg::FIFO_CNT_W'(pop);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            r_wr  <= n_wr;
            r_rd  <= n_rd;
            r_cnt <= n_cnt;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push.n_tok != 2'd0) begin
            r_mem[r_wr] <= i_push.tok0;
        end
        if (i_push.n_tok == 2'd2) begin
            r_mem[wr_next] <= i_push.tok1;
        end
    end

endmodule

`default_nettype wire

### rtl/rts_checker.sv
// ----------------------------------------------------------------------------
// rts_checker
// Port-level checks for the RPN token scanner, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

module rts_checker (
    input wire logic               i_clk,
    input wire logic               i_rst_n,
    input wire logic               o_out_valid,
    input wire logic               i_out_ready,
    input wire rts_pkg::t_out_item o_out_item
);

    // Stalled token stays offered
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=> o_out_valid)
        else $error("out item dropped while stalled");

    a_out_stable: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=> $stable(o_out_item))
        else $error("out item changed while stalled");

    // Only number tokens carry a mantissa or point count
    a_num_payload: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && (o_out_item.token_kind != rts_pkg::KIND_NUMBER)
        |-> (o_out_item.mantissa == '0) && (o_out_item.fraction_digits == '0))
        else $error("non-number token with numeric payload");

    // Only error tokens carry text
    a_err_payload: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && (o_out_item.token_kind != rts_pkg::KIND_ERR)
        |-> (o_out_item.error_length == '0) && (o_out_item.error_text == '0))
        else $error("non-error token with text payload");

    // Queue is empty after reset
    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid)
        else $error("token offered right after reset");

endmodule

bind rpn_token_scanner rts_checker u_rts_checker (.*);

`default_nettype wire
